/* design/act_pkg.sv */
// ----------------------------------------------------------------------------
// act_pkg: shared types and constants of the ARP cache table
// Table geometry, operation and status codes, word layouts and the
// controller state type.
// ----------------------------------------------------------------------------
package act_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int ENTRY_W   = IP_W + MAC_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = MAC_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IP_W-1:0]  ip_address;
        logic [MAC_W-1:0] mac_address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MAC_W-1:0]    found_mac;
    } t_rsp;

    // Request from the controller to the entry memory
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

/* design/arp_cache_table_unit.sv */
// ----------------------------------------------------------------------------
// arp_cache_table_unit: IPv4-to-MAC address cache
// Command-driven table with a static local entry and dynamic entries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a command word on i_req and raise start; it is taken at a clock
//   edge where busy is low. busy stays high until the command finishes.
//   Exactly one result word follows each command, on o_rsp for a single
//   cycle marked by o_done; the receiver cannot hold it off.
//   Lookup, insert, delete and update scan the entry memory one entry per
//   cycle through its single read port. Init and unknown commands skip the
//   scan. A new command may be given in the cycle the result is shown.
//   The two configuration registers (own IP, own MAC) are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while idle,
//   which the block does not enforce. They reach the static entry at the
//   next init. Reset clears the dynamic valid bits at once and, with busy
//   high, writes the static entry as zero in the boot state.
// ----------------------------------------------------------------------------
module arp_cache_table_unit
    import act_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_done,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [IP_W-1:0]    r_own_ip;
    logic [MAC_W-1:0]   r_own_mac;
    t_mem_req           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_IP: begin
                    r_own_ip <= i_cfg_data[IP_W-1:0];
                end
                CFG_OWN_MAC: begin
                    r_own_mac <= i_cfg_data[MAC_W-1:0];
                end
                default: begin
                    r_own_ip <= r_own_ip;
                end
            endcase
        end
    end

    act_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_own_ip  (r_own_ip),
        .i_own_mac (r_own_mac),
        .i_rdata   (mem_rdata),
        .o_mem     (mem_req),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp)
    );

    act_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule

/* design/act_ram.sv */
// ----------------------------------------------------------------------------
// act_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module act_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/act_ctrl.sv */
// ----------------------------------------------------------------------------
// act_ctrl: command sequencer of the ARP cache table
// Scans the entry memory one entry a cycle, holds the valid bits, and
// applies the write back and the result of each command.
// ----------------------------------------------------------------------------
module act_ctrl
    import act_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_req               i_req,
    input  logic [IP_W-1:0]    i_own_ip,
    input  logic [MAC_W-1:0]   i_own_mac,
    input  logic [ENTRY_W-1:0] i_rdata,
    output t_mem_req           o_mem,
    output logic               o_busy,
    output logic               o_done,
    output t_rsp               o_rsp
);

    t_state                   r_state, n_state;
    t_req                     r_req, n_req;
    logic [CNT_W-1:0]         r_addr, n_addr;
    logic                     r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic                     r_hit, n_hit;
    logic [IDX_W-1:0]         r_hit_idx, n_hit_idx;
    logic [MAC_W-1:0]         r_hit_mac, n_hit_mac;
    logic                     r_free_found, n_free_found;
    logic [IDX_W-1:0]         r_free_idx, n_free_idx;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic                     r_done, n_done;
    t_rsp                     r_rsp, n_rsp;

    logic [IP_W-1:0]  ent_ip;
    logic [MAC_W-1:0] ent_mac;
    logic             cmp_match;
    logic             cmp_last;
    logic             issue;
    logic             accept;
    logic             scan_op;

    assign ent_ip  = i_rdata[ENTRY_W-1:MAC_W];
    assign ent_mac = i_rdata[MAC_W-1:0];
    assign accept  = i_start && (r_state == S_IDLE);
    assign scan_op = (i_req.operation == OP_INSERT) || (i_req.operation == OP_DELETE)
                  || (i_req.operation == OP_LOOKUP) || (i_req.operation == OP_UPDATE);

    // Compare the entry returned by the memory; delete skips the static entry
    assign cmp_match = (r_state == S_SCAN) && r_cmp_vld && r_valid[r_cmp_idx]
                    && (ent_ip == r_req.ip_address)
                    && ((r_req.operation != OP_DELETE)
                        || ((r_cmp_idx != '0) && (ent_mac == r_req.mac_address)));
    assign cmp_last  = r_cmp_vld && (r_cmp_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign issue     = (r_state == S_SCAN) && (r_addr < CNT_W'(TABLE_ENTRIES)) && !cmp_match;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BOOT: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = scan_op ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (cmp_match || cmp_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Scan bookkeeping, valid bits and result word
    always_comb begin
        n_req        = r_req;
        n_addr       = r_addr;
        n_cmp_vld    = issue;
        n_cmp_idx    = r_addr[IDX_W-1:0];
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_mac    = r_hit_mac;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_done       = 1'b0;
        n_rsp        = r_rsp;

        if (accept) begin
            n_req        = i_req;
            n_addr       = '0;
            n_hit        = 1'b0;
            n_free_found = 1'b0;
        end

        if (issue) begin
            n_addr = r_addr + CNT_W'(1);
        end

        // Capture the first hit and the lowest free dynamic slot
        if (cmp_match && !r_hit) begin
            n_hit     = 1'b1;
            n_hit_idx = r_cmp_idx;
            n_hit_mac = ent_mac;
        end
        if ((r_state == S_SCAN) && r_cmp_vld && !r_valid[r_cmp_idx]
                && (r_cmp_idx != '0) && !r_free_found) begin
            n_free_found = 1'b1;
            n_free_idx   = r_cmp_idx;
        end

        if (r_state == S_FINISH) begin
            n_done          = 1'b1;
            n_rsp.status    = ST_NOT_FOUND;
            n_rsp.found_mac = '0;
            case (r_req.operation)
                OP_INIT: begin
                    n_valid      = TABLE_ENTRIES'(1);
                    n_rsp.status = ST_OK;
                end
                OP_INSERT: begin
                    if (r_hit) begin
                        n_rsp.status = ST_PRESENT;
                    end else if (r_free_found) begin
                        n_valid[r_free_idx] = 1'b1;
                        n_rsp.status        = ST_OK;
                    end else begin
                        n_rsp.status = ST_FULL;
                    end
                end
                OP_DELETE: begin
                    if (r_hit) begin
                        n_valid[r_hit_idx] = 1'b0;
                        n_rsp.status       = ST_OK;
                    end
                end
                OP_LOOKUP: begin
                    if (r_hit) begin
                        n_rsp.status    = ST_OK;
                        n_rsp.found_mac = r_hit_mac;
                    end
                end
                OP_UPDATE: begin
                    if (r_hit) begin
                        n_rsp.status = ST_OK;
                    end
                end
                default: begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Memory requests: reads while scanning, zero write at boot, write back at the end
    always_comb begin
        o_mem.re    = issue;
        o_mem.raddr = r_addr[IDX_W-1:0];
        o_mem.we    = 1'b0;
        o_mem.waddr = '0;
        o_mem.wdata = {r_req.ip_address, r_req.mac_address};
        case (r_state)
            S_BOOT: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = '0;
            end
            S_FINISH: begin
                if (r_req.operation == OP_INIT) begin
                    o_mem.we    = 1'b1;
                    o_mem.wdata = {i_own_ip, i_own_mac};
                end else if ((r_req.operation == OP_INSERT) && !r_hit && r_free_found) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_free_idx;
                end else if ((r_req.operation == OP_UPDATE) && r_hit) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_hit_idx;
                end
            end
            default: begin
                o_mem.we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_BOOT;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= TABLE_ENTRIES'(1);
            r_done       <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_state      <= n_state;
            r_cmp_vld    <= n_cmp_vld;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_valid      <= n_valid;
            r_done       <= n_done;
            r_addr       <= n_addr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_hit_mac  <= n_hit_mac;
        r_free_idx <= n_free_idx;
        r_rsp      <= n_rsp;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // The static entry never loses its valid bit
    a_static_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0])
        else $error("static entry lost its valid bit");

    // A result follows only the finishing step
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_FINISH))
        else $error("result without a finishing step");

    // A non-zero MAC is only ever reported with status ok
    a_mac_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_rsp.found_mac != '0)) |-> (r_rsp.status == ST_OK))
        else $error("found MAC reported on a failed command");

    // No write back while the scan reads the memory
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_mem.we)
        else $error("memory write during scan");

endmodule
